FILE: hw/rtl/fpd_pkg.sv
// Shared types, widths and tables of the fisheye point distortion pipeline.
// No dependencies; every module of the block imports this package.
package fpd_pkg;

  localparam int XW           = 32;
  localparam int R_W          = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int SQRT_STEPS   = 32;
  localparam int REM_W        = 35;
  localparam int CORDIC_STEPS = 31;
  localparam int CW           = 41;
  localparam int ZW           = 33;
  localparam int T_W          = 30;
  localparam int TD_W         = 43;
  localparam int DIV_STEPS    = 33;
  localparam int Q_W          = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_FOUR  = 3'd3;

  typedef struct packed {
    logic signed [XW-1:0] in_x;
    logic signed [XW-1:0] in_y;
  } in_t;

  typedef struct packed {
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] coef_one;
    logic signed [31:0] coef_two;
    logic signed [31:0] coef_three;
    logic signed [31:0] coef_four;
  } coef_t;

  typedef struct packed {
    logic [XW-1:0] ax;
    logic [XW-1:0] ay;
    logic          sx;
    logic          sy;
  } pt_t;

  typedef struct packed {
    pt_t            pt;
    logic [R_W-1:0] r;
  } carry_t;

  function automatic logic [29:0] atan_tab(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q4.28 product rounding: (m + 2^27) >> 28.
  function automatic logic [35:0] qround(input logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, m} + 65'd134217728;
    return s[63:28];
  endfunction

endpackage

FILE: hw/rtl/fpd_sqrt.sv
// Magnitudes, squared radius and a one-bit-per-stage integer square root.
// Depends on fpd_pkg.
module fpd_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  fpd_pkg::in_t            data_i,
  output logic                    vld_o,
  output fpd_pkg::pt_t            pt_o,
  output logic [fpd_pkg::R_W-1:0] r_o
);
  import fpd_pkg::*;

  pt_t         a_pt_r, a_pt_nxt;
  logic        a_vld_r;
  pt_t         b_pt_r;
  logic        b_vld_r;
  logic [63:0] sqx_r, sqy_r;

  logic [SQRT_STEPS:0] vld_r;
  pt_t                 pt_r   [SQRT_STEPS+1];
  logic [63:0]         rad_r  [SQRT_STEPS+1];
  logic [REM_W-1:0]    rem_r  [SQRT_STEPS+1];
  logic [R_W-1:0]      root_r [SQRT_STEPS+1];

  always_comb begin
    a_pt_nxt.ax = data_i.in_x[XW-1] ? XW'(-data_i.in_x) : XW'(data_i.in_x);
    a_pt_nxt.ay = data_i.in_y[XW-1] ? XW'(-data_i.in_y) : XW'(data_i.in_y);
    a_pt_nxt.sx = data_i.in_x[XW-1];
    a_pt_nxt.sy = data_i.in_y[XW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r  <= vld_i;
      b_vld_r  <= a_vld_r;
      vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pt_r    <= a_pt_nxt;
      sqx_r     <= a_pt_r.ax * a_pt_r.ax;
      sqy_r     <= a_pt_r.ay * a_pt_r.ay;
      b_pt_r    <= a_pt_r;
      rad_r[0]  <= sqx_r + sqy_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      pt_r[0]   <= b_pt_r;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [REM_W-1:0] rem_sh, trial, rem_nxt;
    logic             ge;
    always_comb begin
      rem_sh  = {rem_r[k][REM_W-3:0], rad_r[k][63:62]};
      trial   = {1'b0, root_r[k], 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? rem_sh - trial : rem_sh;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= {root_r[k][R_W-2:0], ge};
        rad_r[k+1]  <= {rad_r[k][61:0], 2'b00};
        pt_r[k+1]   <= pt_r[k];
      end
    end
  end

  assign vld_o = vld_r[SQRT_STEPS];
  assign pt_o  = pt_r[SQRT_STEPS];
  assign r_o   = root_r[SQRT_STEPS];

endmodule

FILE: hw/rtl/fpd_cordic.sv
// Vectoring CORDIC, one micro-rotation per stage, giving theta = atan(r) in Q2.28.
// Depends on fpd_pkg.
module fpd_cordic (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  fpd_pkg::pt_t            pt_i,
  input  logic [fpd_pkg::R_W-1:0] r_i,
  output logic                    vld_o,
  output fpd_pkg::carry_t         carry_o,
  output logic [fpd_pkg::T_W-1:0] t_o
);
  import fpd_pkg::*;

  localparam logic signed [CW-1:0] CX0 = CW'(64'd1 << 30);

  logic [CORDIC_STEPS:0]  vld_r;
  carry_t                 carry_r [CORDIC_STEPS+1];
  logic signed [CW-1:0]   cx_r    [CORDIC_STEPS+1];
  logic signed [CW-1:0]   cy_r    [CORDIC_STEPS+1];
  logic signed [ZW-1:0]   z_r     [CORDIC_STEPS+1];
  logic                   fin_vld_r;
  carry_t                 fin_carry_r;
  logic [T_W-1:0]         t_r;
  logic signed [ZW-1:0]   z_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0]  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0]  <= vld_i;
      fin_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]       <= CX0;
      cy_r[0]       <= $signed({3'b000, r_i, 6'b000000});
      z_r[0]        <= '0;
      carry_r[0].pt <= pt_i;
      carry_r[0].r  <= r_i;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_tab(i));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] + ANG;
        end else begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] - ANG;
        end
        carry_r[i+1] <= carry_r[i];
      end
    end
  end

  assign z_fin = z_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      t_r         <= z_fin[ZW-1] ? '0 : z_fin[T_W+1:2];
      fin_carry_r <= carry_r[CORDIC_STEPS];
    end
  end

  assign vld_o   = fin_vld_r;
  assign carry_o = fin_carry_r;
  assign t_o     = t_r;

endmodule

FILE: hw/rtl/fpd_poly.sv
// Odd powers of theta (a multiply stage and a rounding stage per power) and the distortion polynomial theta_d.
// Depends on fpd_pkg.
module fpd_poly (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  fpd_pkg::carry_t                 carry_i,
  input  logic [fpd_pkg::T_W-1:0]         t_i,
  input  fpd_pkg::coef_t                  coef_i,
  output logic                            vld_o,
  output fpd_pkg::carry_t                 carry_o,
  output logic signed [fpd_pkg::TD_W-1:0] td_o
);
  import fpd_pkg::*;

  localparam int P_LAT = 13;
  localparam int TM_W  = 40;

  logic [P_LAT-1:0] vld_r;
  carry_t           carry_r [P_LAT];
  logic [T_W-1:0]   t_r     [12];
  logic [29:0]      t2_r    [7];
  logic [29:0]      t3_r    [7];
  logic [31:0]      t5_r    [5];
  logic [33:0]      t7_r    [3];
  logic [34:0]      t9_r;
  logic [59:0]      m0_r, m2_r, m4_r;
  logic [61:0]      m6_r;
  logic [63:0]      m8_r;
  logic [31:0]      kmag_r  [4];
  logic [3:0]       ksgn_r;
  logic [61:0]      km1_r;
  logic [63:0]      km2_r;
  logic [65:0]      km3_r;
  logic [66:0]      km4_r;
  logic [TM_W-1:0]  mg1, mg2, mg3, mg4;
  logic [TM_W-1:0]  term_r  [4];
  logic [TD_W-1:0]  td_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[P_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    kmag_r[0] <= coef_i.coef_one[31]   ? 32'(-coef_i.coef_one)   : 32'(coef_i.coef_one);
    kmag_r[1] <= coef_i.coef_two[31]   ? 32'(-coef_i.coef_two)   : 32'(coef_i.coef_two);
    kmag_r[2] <= coef_i.coef_three[31] ? 32'(-coef_i.coef_three) : 32'(coef_i.coef_three);
    kmag_r[3] <= coef_i.coef_four[31]  ? 32'(-coef_i.coef_four)  : 32'(coef_i.coef_four);
    ksgn_r    <= {coef_i.coef_four[31], coef_i.coef_three[31],
                  coef_i.coef_two[31], coef_i.coef_one[31]};
  end

  always_comb begin
    mg1 = TM_W'(km1_r >> 28);
    mg2 = TM_W'(km2_r >> 28);
    mg3 = TM_W'(km3_r >> 28);
    mg4 = TM_W'(km4_r >> 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0] <= carry_i;
      for (int j = 1; j < P_LAT; j++) begin
        carry_r[j] <= carry_r[j-1];
      end
      t_r[0] <= t_i;
      for (int j = 1; j < 12; j++) begin
        t_r[j] <= t_r[j-1];
      end
      m0_r    <= t_i * t_i;
      t2_r[0] <= 30'(qround(64'(m0_r)));
      m2_r    <= t2_r[0] * t_r[1];
      t2_r[1] <= t2_r[0];
      t3_r[0] <= 30'(qround(64'(m2_r)));
      t2_r[2] <= t2_r[1];
      m4_r    <= t3_r[0] * t2_r[2];
      t3_r[1] <= t3_r[0];
      t2_r[3] <= t2_r[2];
      t5_r[0] <= 32'(qround(64'(m4_r)));
      t3_r[2] <= t3_r[1];
      t2_r[4] <= t2_r[3];
      m6_r    <= t5_r[0] * t2_r[4];
      t5_r[1] <= t5_r[0];
      t3_r[3] <= t3_r[2];
      t2_r[5] <= t2_r[4];
      t7_r[0] <= 34'(qround(64'(m6_r)));
      t5_r[2] <= t5_r[1];
      t3_r[4] <= t3_r[3];
      t2_r[6] <= t2_r[5];
      m8_r    <= t7_r[0] * t2_r[6];
      t7_r[1] <= t7_r[0];
      t5_r[3] <= t5_r[2];
      t3_r[5] <= t3_r[4];
      t9_r    <= 35'(qround(m8_r));
      t7_r[2] <= t7_r[1];
      t5_r[4] <= t5_r[3];
      t3_r[6] <= t3_r[5];
      km1_r   <= kmag_r[0] * t3_r[6];
      km2_r   <= kmag_r[1] * t5_r[4];
      km3_r   <= kmag_r[2] * t7_r[2];
      km4_r   <= kmag_r[3] * t9_r;
      term_r[0] <= ksgn_r[0] ? TM_W'(-mg1) : mg1;
      term_r[1] <= ksgn_r[1] ? TM_W'(-mg2) : mg2;
      term_r[2] <= ksgn_r[2] ? TM_W'(-mg3) : mg3;
      term_r[3] <= ksgn_r[3] ? TM_W'(-mg4) : mg4;
      td_r <= TD_W'({1'b0, t_r[11]})
            + TD_W'($signed(term_r[0])) + TD_W'($signed(term_r[1]))
            + TD_W'($signed(term_r[2])) + TD_W'($signed(term_r[3]));
    end
  end

  assign vld_o   = vld_r[P_LAT-1];
  assign carry_o = carry_r[P_LAT-1];
  assign td_o    = $signed(td_r);

endmodule

FILE: hw/rtl/fpd_lane.sv
// One output coordinate: restoring divider for |c|/r, scale by theta_d, saturation.
// Depends on fpd_pkg.
module fpd_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_i,
  input  logic [fpd_pkg::XW-1:0]          ac_i,
  input  logic                            sgn_i,
  input  logic [fpd_pkg::R_W-1:0]         r_i,
  input  logic signed [fpd_pkg::TD_W-1:0] td_i,
  output logic                            vld_o,
  output logic signed [fpd_pkg::XW-1:0]   c_o,
  output logic                            sat_o
);
  import fpd_pkg::*;

  localparam int LN_LAT = DIV_STEPS + 4;
  localparam int MAG_W  = 40;
  localparam logic [MAG_W-1:0] SAT_NEG_MAG = MAG_W'(64'h8000_0000);
  localparam logic [MAG_W-1:0] SAT_POS_MAG = MAG_W'(64'h7FFF_FFFF);

  logic [LN_LAT-1:0] vld_r;
  logic [TD_W-1:0]   ad_r   [DIV_STEPS+1];
  logic              neg_r  [DIV_STEPS+1];
  logic              zero_r [DIV_STEPS+1];
  logic [R_W-1:0]    r_r    [DIV_STEPS+1];
  logic [R_W-1:0]    rem_r  [DIV_STEPS+1];
  logic [Q_W-1:0]    q_r    [DIV_STEPS+1];
  logic [54:0]       plo_r;
  logic [53:0]       phi_r;
  logic              negm_r, zerom_r, negs_r, zeros_r;
  logic [75:0]       full;
  logic [MAG_W-1:0]  mag_r;
  logic [XW-1:0]     c_r;
  logic              sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LN_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0]   <= td_i[TD_W-1] ? TD_W'(-td_i) : TD_W'(td_i);
      neg_r[0]  <= sgn_i ^ td_i[TD_W-1];
      zero_r[0] <= (r_i == '0);
      r_r[0]    <= r_i;
      rem_r[0]  <= ac_i;
      q_r[0]    <= '0;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [R_W:0] rsh;
    logic         ge;
    if (s == 0) begin : g_first
      assign rsh = {1'b0, rem_r[s]};
    end else begin : g_rest
      assign rsh = {rem_r[s], 1'b0};
    end
    assign ge = (rsh >= {1'b0, r_r[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? R_W'(rsh - {1'b0, r_r[s]}) : rsh[R_W-1:0];
        q_r[s+1]    <= {q_r[s][Q_W-2:0], ge};
        ad_r[s+1]   <= ad_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
        r_r[s+1]    <= r_r[s];
      end
    end
  end

  assign full = 76'({phi_r, 22'b0}) + 76'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= ad_r[DIV_STEPS][21:0] * q_r[DIV_STEPS];
      phi_r   <= ad_r[DIV_STEPS][TD_W-1:22] * q_r[DIV_STEPS];
      negm_r  <= neg_r[DIV_STEPS];
      zerom_r <= zero_r[DIV_STEPS];
      mag_r   <= full[75:36];
      negs_r  <= negm_r;
      zeros_r <= zerom_r;
      if (zeros_r) begin
        c_r   <= '0;
        sat_r <= 1'b0;
      end else if (negs_r) begin
        c_r   <= (mag_r > SAT_NEG_MAG) ? XW'(SAT_NEG_MAG) : XW'(-mag_r);
        sat_r <= (mag_r > SAT_NEG_MAG);
      end else begin
        c_r   <= (mag_r > SAT_POS_MAG) ? XW'(SAT_POS_MAG) : XW'(mag_r);
        sat_r <= (mag_r > SAT_POS_MAG);
      end
    end
  end

  assign vld_o = vld_r[LN_LAT-1];
  assign c_o   = $signed(c_r);
  assign sat_o = sat_r;

endmodule

FILE: hw/rtl/fisheye_point_distort.sv
// Top level of the fisheye point distortion pipeline: coefficient registers,
// the stage chain and a two-entry output buffer. Depends on fpd_pkg and all fpd_ modules.
//
//   port group  direction  handshake              payload
//   in_         input      in_valid / in_ready    fpd_pkg::in_t  (in_x, in_y)
//   out_        output     out_valid / out_ready  fpd_pkg::out_t (out_x, out_y, saturated)
//   cfg_        input      cfg_we                 cfg_idx, cfg_wdata
//
// One transaction is accepted per cycle while the output buffer is not full; its result
// passes through the 32-step square root, 31-step CORDIC and 33-step dividers.
// The whole pipeline advances together; it holds only while the output buffer is full.
// Reset clears the valid bits, the buffer count and the coefficients.
module fisheye_point_distort (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpd_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fpd_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [fpd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                   cfg_wdata
);
  import fpd_pkg::*;

  coef_t               coef_r;
  logic                en;
  logic                sq_vld;
  pt_t                 sq_pt;
  logic [R_W-1:0]      sq_r;
  logic                co_vld;
  carry_t              co_carry;
  logic [T_W-1:0]      co_t;
  logic                po_vld;
  carry_t              po_carry;
  logic signed [TD_W-1:0] po_td;
  logic                lx_vld, ly_vld, lx_sat, ly_sat;
  logic signed [XW-1:0] lx_c, ly_c;
  logic                tail_vld, push, pop;
  out_t                tail;
  out_t                ent0_r, ent1_r, ent0_nxt, ent1_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_COEF_ONE:   coef_r.coef_one   <= $signed(cfg_wdata);
        CFG_COEF_TWO:   coef_r.coef_two   <= $signed(cfg_wdata);
        CFG_COEF_THREE: coef_r.coef_three <= $signed(cfg_wdata);
        CFG_COEF_FOUR:  coef_r.coef_four  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  fpd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_valid && in_ready),
    .data_i(in_data), .vld_o(sq_vld), .pt_o(sq_pt), .r_o(sq_r)
  );

  fpd_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sq_vld), .pt_i(sq_pt), .r_i(sq_r),
    .vld_o(co_vld), .carry_o(co_carry), .t_o(co_t)
  );

  fpd_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(co_vld), .carry_i(co_carry),
    .t_i(co_t), .coef_i(coef_r), .vld_o(po_vld), .carry_o(po_carry), .td_o(po_td)
  );

  fpd_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(po_vld), .ac_i(po_carry.pt.ax),
    .sgn_i(po_carry.pt.sx), .r_i(po_carry.r), .td_i(po_td),
    .vld_o(lx_vld), .c_o(lx_c), .sat_o(lx_sat)
  );

  fpd_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(po_vld), .ac_i(po_carry.pt.ay),
    .sgn_i(po_carry.pt.sy), .r_i(po_carry.r), .td_i(po_td),
    .vld_o(ly_vld), .c_o(ly_c), .sat_o(ly_sat)
  );

  assign tail_vld        = lx_vld && ly_vld;
  assign tail.out_x      = lx_c;
  assign tail.out_y      = ly_c;
  assign tail.saturated  = lx_sat || ly_sat;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;
  assign push      = en && tail_vld;
  assign pop       = out_valid && out_ready;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      ent0_nxt = ent1_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        ent0_nxt = tail;
      end else begin
        ent1_nxt = tail;
      end
    end
    cnt_nxt = 2'(cnt_r + 2'(push) - 2'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && cnt_r == 2'd2)
    else $error("input stalled while output buffer not full");

  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cnt_r == 2'd1 && !push) |=> !out_valid)
    else $error("output valid after last transaction drained");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_x == 32'sh7FFF_FFFF || out_data.out_x == 32'sh8000_0000 ||
       out_data.out_y == 32'sh7FFF_FFFF || out_data.out_y == 32'sh8000_0000))
    else $error("saturation flag without a clipped coordinate");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lx_vld == ly_vld)
    else $error("coordinate lanes out of step");

endmodule
